[design/yuyv2bgr_pkg.sv]
// ----------------------------------------------------------------------------
// yuyv2bgr_pkg
// Shared types and constants for the YUYV pair to BGR888 converter.
// ----------------------------------------------------------------------------
package yuyv2bgr_pkg;

  localparam int PIX_W  = 8;
  localparam int FX_SH  = 16;
  // 9-bit signed chroma times 18-bit signed coefficient; sums also fit
  localparam int ACC_W  = 27;
  localparam int COEF_W = 18;

  // full-range BT.601 coefficients, Q.16
  localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd91881;
  localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22554;
  localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd46802;
  localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd116130;

  localparam logic [PIX_W-1:0] CHROMA_OFS = 8'd128;
  localparam logic [PIX_W-1:0] CHAN_MAX   = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
  } yuyv_pair_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] blue_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] red_second;
  } bgr_pair_t;

  // truncate Q.16 to integer, clamp to 0..255
  function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (|acc[ACC_W-2:FX_SH+PIX_W]) begin
      res = CHAN_MAX;
    end else begin
      res = acc[FX_SH+PIX_W-1:FX_SH];
    end
    return res;
  endfunction

endpackage

[design/yuyv_pair_to_bgr888_core.sv]
// ----------------------------------------------------------------------------
// yuyv_pair_to_bgr888_core
// Four-stage pipeline converting one YUYV macropixel into two BGR888 pixels.
// ----------------------------------------------------------------------------
//  channel | direction | payload      | handshake
//  in_     | input     | yuyv_pair_t  | in_valid / in_stall
//  out_    | output    | bgr_pair_t   | out_valid / out_stall
//
//  One pair accepted per clock when the output is not held off.
//  Stages: input register, chroma multipliers, channel sums, clamp into the
//  output register.
//  rst_n (synchronous) clears the stage valid bits only.
//  Each stage loads when it is empty or the stage after it moves, so bubbles
//  fill up under out_stall; in_stall rises only with all four stages full.
// ----------------------------------------------------------------------------
module yuyv_pair_to_bgr888_core
  import yuyv2bgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  yuyv_pair_t in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output bgr_pair_t  out_data
);

  logic en1, en2, en3, en4;

  // stage 1: input register
  logic       s1_valid_r;
  yuyv_pair_t s1_data_r;

  // stage 2: products
  logic                    s2_valid_r;
  logic [PIX_W-1:0]        s2_y0_r, s2_y1_r;
  logic signed [ACC_W-1:0] s2_rv_r, s2_gu_r, s2_gv_r, s2_bu_r;
  logic signed [ACC_W-1:0] s2_rv_nxt, s2_gu_nxt, s2_gv_nxt, s2_bu_nxt;
  logic signed [PIX_W:0]   du, dv;

  // stage 3: channel sums
  logic                    s3_valid_r;
  logic signed [ACC_W-1:0] s3_b0_r, s3_g0_r, s3_r0_r, s3_b1_r, s3_g1_r, s3_r1_r;
  logic signed [ACC_W-1:0] s3_b0_nxt, s3_g0_nxt, s3_r0_nxt;
  logic signed [ACC_W-1:0] s3_b1_nxt, s3_g1_nxt, s3_r1_nxt;
  logic signed [ACC_W-1:0] ys0, ys1;

  // stage 4: output register
  logic      out_valid_r;
  bgr_pair_t out_data_r;
  bgr_pair_t out_data_nxt;

  assign en4 = !out_valid_r || !out_stall;
  assign en3 = !s3_valid_r || en4;
  assign en2 = !s2_valid_r || en3;
  assign en1 = !s1_valid_r || en2;

  assign in_stall  = !en1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // products are sized by the accumulator, operands sign-extended first
  always_comb begin
    du = $signed({1'b0, s1_data_r.chroma_blue}) - $signed({1'b0, CHROMA_OFS});
    dv = $signed({1'b0, s1_data_r.chroma_red})  - $signed({1'b0, CHROMA_OFS});
    s2_rv_nxt = dv * COEF_RV;
    s2_gu_nxt = du * COEF_GU;
    s2_gv_nxt = dv * COEF_GV;
    s2_bu_nxt = du * COEF_BU;
  end

  always_comb begin
    ys0 = $signed({{(ACC_W-PIX_W-FX_SH){1'b0}}, s2_y0_r, {FX_SH{1'b0}}});
    ys1 = $signed({{(ACC_W-PIX_W-FX_SH){1'b0}}, s2_y1_r, {FX_SH{1'b0}}});
    s3_b0_nxt = ys0 + s2_bu_r;
    s3_g0_nxt = ys0 - s2_gu_r - s2_gv_r;
    s3_r0_nxt = ys0 + s2_rv_r;
    s3_b1_nxt = ys1 + s2_bu_r;
    s3_g1_nxt = ys1 - s2_gu_r - s2_gv_r;
    s3_r1_nxt = ys1 + s2_rv_r;
  end

  always_comb begin
    out_data_nxt.blue_first   = clamp_q16(s3_b0_r);
    out_data_nxt.green_first  = clamp_q16(s3_g0_r);
    out_data_nxt.red_first    = clamp_q16(s3_r0_r);
    out_data_nxt.blue_second  = clamp_q16(s3_b1_r);
    out_data_nxt.green_second = clamp_q16(s3_g1_r);
    out_data_nxt.red_second   = clamp_q16(s3_r1_r);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r  <= in_valid;
      if (en2) s2_valid_r  <= s1_valid_r;
      if (en3) s3_valid_r  <= s2_valid_r;
      if (en4) out_valid_r <= s3_valid_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_data_r <= in_data;
    end
    if (en2) begin
      s2_y0_r <= s1_data_r.luma_first;
      s2_y1_r <= s1_data_r.luma_second;
      s2_rv_r <= s2_rv_nxt;
      s2_gu_r <= s2_gu_nxt;
      s2_gv_r <= s2_gv_nxt;
      s2_bu_r <= s2_bu_nxt;
    end
    if (en3) begin
      s3_b0_r <= s3_b0_nxt;
      s3_g0_r <= s3_g0_nxt;
      s3_r0_r <= s3_r0_nxt;
      s3_b1_r <= s3_b1_nxt;
      s3_g1_r <= s3_g1_nxt;
      s3_r1_r <= s3_r1_nxt;
    end
    if (en4) begin
      out_data_r <= out_data_nxt;
    end
  end

  // input is held off only when every stage is full and the output blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && s3_valid_r && out_valid_r && out_stall))
    else $error("in_stall raised with room in the pipe");

  // a result only appears if the sum stage held an item
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) && !s3_valid_r |=> !out_valid_r)
    else $error("result appeared from an empty stage");

  // sum stage holds while the output is blocked
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && out_valid_r && out_stall |=> $stable(s3_b0_r) && $stable(s3_g1_r))
    else $error("sum stage changed under stall");

  // negative sum clamps to zero
  a_clamp_low: assert property (@(posedge clk) disable iff (!rst_n)
    en4 && s3_valid_r && s3_b0_r[ACC_W-1] |=> out_data_r.blue_first == '0)
    else $error("negative blue not clamped");

endmodule
